// ===== design/csrm_pkg.sv =====
// Package for the class-split running mean block: payload structs, sizes, codes.
// Used by every module under design/; depends on nothing else.

package csrm_pkg;

  localparam int MAX_DIM_DEFAULT    = 64;
  localparam int COUNT_BITS_DEFAULT = 17;

  localparam int FEAT_W   = 16;
  localparam int ELEM_W   = 6;
  localparam int DIM_W    = 7;
  localparam int PERIOD_W = 16;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd10;
  localparam logic [DIM_W-1:0]    DIM_RESET    = 7'd40;

  // Register index codes, decoded from paddr[2].
  localparam logic REG_PERIOD = 1'b0;
  localparam logic REG_DIM    = 1'b1;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic signed [FEAT_W-1:0] feature_value;
    logic [ELEM_W-1:0]        element_index;
    logic signed [FEAT_W-1:0] score_a;
    logic signed [FEAT_W-1:0] score_b;
    logic signed [FEAT_W-1:0] score_c;
    logic                     first_frame;
    logic                     last_frame;
  } in_item_t;

  typedef struct packed {
    logic [ELEM_W-1:0]        out_index;
    logic signed [FEAT_W-1:0] speech_mean;
    logic signed [FEAT_W-1:0] noise_mean;
    logic                     end_of_vector;
    logic                     end_of_utterance;
  } out_item_t;

  // One classified element on its way from the front to the back.
  typedef struct packed {
    logic [ELEM_W-1:0]        elem;
    logic signed [FEAT_W-1:0] value;
    logic                     noise;
    logic                     drop;
    logic                     first;
    logic                     emit;
    logic                     last;
    logic                     eov;
  } work_item_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_UPDATE,
    BK_DIVIDE
  } back_state_t;

endpackage

// ===== design/csrm_div.sv =====
// Iterative signed-by-unsigned divider, one quotient bit per cycle.
// Depends on csrm_pkg.

module csrm_div #(
  parameter int COUNT_BITS = csrm_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            start,
  input  logic signed [csrm_pkg::FEAT_W+COUNT_BITS-1:0]   dividend,
  input  logic [COUNT_BITS-1:0]                           divisor,
  output logic                                            busy,
  output logic signed [csrm_pkg::FEAT_W-1:0]              quotient
);
  import csrm_pkg::*;

  localparam int SUM_W = FEAT_W + COUNT_BITS;
  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [CNT_W-1:0]      cnt;
  logic [COUNT_BITS-1:0] rem;
  logic [COUNT_BITS-1:0] dvs;
  logic [SUM_W-1:0]      quo;
  logic                  neg;
  logic                  zero;

  logic [SUM_W-1:0]      mag;
  logic [COUNT_BITS:0]   trial;
  logic [COUNT_BITS:0]   diff;
  logic                  qbit;
  logic [FEAT_W-1:0]     q_lo;

  assign mag   = dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
  assign trial = {rem, quo[SUM_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign qbit  = (trial >= {1'b0, dvs});
  assign busy  = (cnt != '0);
  assign q_lo  = quo[FEAT_W-1:0];

  always_comb begin
    if (zero) begin
      quotient = '0;
    end else if (neg) begin
      quotient = ~q_lo + FEAT_W'(1);
    end else begin
      quotient = q_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(SUM_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= mag;
      rem  <= '0;
      dvs  <= divisor;
      neg  <= dividend[SUM_W-1];
      zero <= (divisor == '0);
    end else if (busy) begin
      rem <= qbit ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
      quo <= {quo[SUM_W-2:0], qbit};
    end
  end

endmodule

// ===== design/csrm_queue.sv =====
// Short first-in first-out queue between the front and the back.
// Depends on csrm_pkg for its depth.

module csrm_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         valid,
  output logic [W-1:0] pop_data
);
  import csrm_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]     slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign valid    = (count != '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/csrm_front.sv =====
// Front end: accepts elements, classifies frames at their first element,
// keeps frame counts and the period phase. Depends on csrm_pkg.

module csrm_front #(
  parameter int MAX_DIM    = csrm_pkg::MAX_DIM_DEFAULT,
  parameter int COUNT_BITS = csrm_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  csrm_pkg::in_item_t                in_data,
  input  logic [csrm_pkg::PERIOD_W-1:0]     period_frames,
  input  logic [csrm_pkg::DIM_W-1:0]        frame_dim,
  input  logic                              q_full,
  output logic                              push,
  output csrm_pkg::work_item_t              entry,
  output logic [COUNT_BITS-1:0]             speech_count,
  output logic [COUNT_BITS-1:0]             noise_count
);
  import csrm_pkg::*;

  localparam int DEPTH = (MAX_DIM < 64) ? MAX_DIM : 64;
  localparam logic [DIM_W-1:0]      DIM_CAP = DIM_W'(DEPTH);
  localparam logic [COUNT_BITS-1:0] CMAX    = {COUNT_BITS{1'b1}};

  // Per-frame latches and counters.
  logic                  lat_noise;
  logic                  lat_drop;
  logic                  lat_first;
  logic                  lat_last;
  logic                  lat_emit;
  logic [COUNT_BITS-1:0] sp_cnt;
  logic [COUNT_BITS-1:0] no_cnt;
  logic [PERIOD_W-1:0]   phase;

  logic [DIM_W-1:0]      dim;
  logic                  accept;
  logic                  in_range;
  logic                  head;
  logic                  noise_h;
  logic                  drop_h;
  logic                  emit_h;
  logic [PERIOD_W-1:0]   per;
  logic [PERIOD_W-1:0]   phase_base;
  logic [PERIOD_W:0]     phase_inc;
  logic [COUNT_BITS-1:0] sp_base;
  logic [COUNT_BITS-1:0] no_base;
  logic [COUNT_BITS-1:0] sp_cnt_next;
  logic [COUNT_BITS-1:0] no_cnt_next;
  logic [PERIOD_W-1:0]   phase_next;

  always_comb begin
    dim = frame_dim;
    if (dim == '0) begin
      dim = DIM_W'(1);
    end
    if (dim > DIM_CAP) begin
      dim = DIM_CAP;
    end
  end

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign in_range = ({1'b0, in_data.element_index} < dim);
  assign head     = (in_data.element_index == '0);

  assign noise_h    = (in_data.score_a > in_data.score_b) ||
                      (in_data.score_c > in_data.score_b);
  assign per        = (period_frames == '0) ? PERIOD_W'(1) : period_frames;
  assign sp_base    = in_data.first_frame ? '0 : sp_cnt;
  assign no_base    = in_data.first_frame ? '0 : no_cnt;
  assign phase_base = in_data.first_frame ? '0 : phase;
  assign phase_inc  = {1'b0, phase_base} + (PERIOD_W + 1)'(1);
  assign drop_h     = noise_h ? (no_base == CMAX) : (sp_base == CMAX);
  assign emit_h     = in_data.last_frame || (phase_inc >= {1'b0, per});
  assign phase_next = emit_h ? '0 : phase_inc[PERIOD_W-1:0];

  always_comb begin
    sp_cnt_next = sp_base;
    no_cnt_next = no_base;
    if (!drop_h) begin
      if (noise_h) begin
        no_cnt_next = no_base + COUNT_BITS'(1);
      end else begin
        sp_cnt_next = sp_base + COUNT_BITS'(1);
      end
    end
  end

  // The queue entry carries the frame's class and the counts after this frame.
  assign push          = accept && in_range;
  assign entry.elem    = in_data.element_index;
  assign entry.value   = in_data.feature_value;
  assign entry.noise   = head ? noise_h : lat_noise;
  assign entry.drop    = head ? drop_h : lat_drop;
  assign entry.first   = head ? in_data.first_frame : lat_first;
  assign entry.emit    = head ? emit_h : lat_emit;
  assign entry.last    = head ? in_data.last_frame : lat_last;
  assign entry.eov     = ({1'b0, in_data.element_index} == (dim - DIM_W'(1)));
  assign speech_count  = head ? sp_cnt_next : sp_cnt;
  assign noise_count   = head ? no_cnt_next : no_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      lat_noise <= 1'b0;
      lat_drop  <= 1'b0;
      lat_first <= 1'b0;
      lat_last  <= 1'b0;
      lat_emit  <= 1'b0;
      sp_cnt    <= '0;
      no_cnt    <= '0;
      phase     <= '0;
    end else if (push && head) begin
      lat_noise <= noise_h;
      lat_drop  <= drop_h;
      lat_first <= in_data.first_frame;
      lat_last  <= in_data.last_frame;
      lat_emit  <= emit_h;
      sp_cnt    <= sp_cnt_next;
      no_cnt    <= no_cnt_next;
      phase     <= phase_next;
    end
  end

endmodule

// ===== design/csrm_back.sv =====
// Back end: per-element sum memories, the two mean divisions and the result register.
// Depends on csrm_pkg and csrm_div.

module csrm_back #(
  parameter int MAX_DIM    = csrm_pkg::MAX_DIM_DEFAULT,
  parameter int COUNT_BITS = csrm_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_valid,
  input  csrm_pkg::work_item_t    q_entry,
  input  logic [COUNT_BITS-1:0]   q_speech_count,
  input  logic [COUNT_BITS-1:0]   q_noise_count,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output csrm_pkg::out_item_t     out_data
);
  import csrm_pkg::*;

  localparam int DEPTH = (MAX_DIM < 64) ? MAX_DIM : 64;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W = FEAT_W + COUNT_BITS;

  logic signed [SUM_W-1:0] speech_mem [DEPTH];
  logic signed [SUM_W-1:0] noise_mem  [DEPTH];
  logic signed [SUM_W-1:0] rd_speech;
  logic signed [SUM_W-1:0] rd_noise;

  back_state_t             state;
  back_state_t             state_next;
  work_item_t              work;
  logic [COUNT_BITS-1:0]   sp_cnt;
  logic [COUNT_BITS-1:0]   no_cnt;

  logic                    div_start;
  logic                    div_busy;
  logic                    sp_busy;
  logic                    no_busy;
  logic                    out_free;
  logic                    out_load;
  logic signed [FEAT_W-1:0] sp_mean;
  logic signed [FEAT_W-1:0] no_mean;
  logic signed [SUM_W-1:0] x_ext;
  logic signed [SUM_W-1:0] new_speech;
  logic signed [SUM_W-1:0] new_noise;
  logic [AW-1:0]           rd_addr;
  logic [AW-1:0]           wr_addr;

  assign rd_addr  = q_entry.elem[AW-1:0];
  assign wr_addr  = work.elem[AW-1:0];
  assign x_ext    = {{COUNT_BITS{work.value[FEAT_W-1]}}, work.value};
  assign div_busy = sp_busy || no_busy;
  assign out_free = !out_valid || !out_stall;

  // A first frame overwrites both sums; a dropped frame leaves them alone.
  always_comb begin
    new_speech = rd_speech;
    new_noise  = rd_noise;
    if (work.first) begin
      new_speech = work.noise ? '0 : x_ext;
      new_noise  = work.noise ? x_ext : '0;
    end else if (!work.drop) begin
      if (work.noise) begin
        new_noise = rd_noise + x_ext;
      end else begin
        new_speech = rd_speech + x_ext;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (q_valid) begin
          state_next = BK_UPDATE;
        end
      end
      BK_UPDATE: begin
        state_next = work.emit ? BK_DIVIDE : BK_IDLE;
      end
      BK_DIVIDE: begin
        if (!div_busy && out_free) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = (state == BK_IDLE) && q_valid;
    div_start = (state == BK_UPDATE) && work.emit;
    out_load  = (state == BK_DIVIDE) && !div_busy && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      work      <= q_entry;
      sp_cnt    <= q_speech_count;
      no_cnt    <= q_noise_count;
      rd_speech <= speech_mem[rd_addr];
      rd_noise  <= noise_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_UPDATE) begin
      speech_mem[wr_addr] <= new_speech;
      noise_mem[wr_addr]  <= new_noise;
    end
  end

  csrm_div #(.COUNT_BITS(COUNT_BITS)) u_div_speech (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (new_speech),
    .divisor  (sp_cnt),
    .busy     (sp_busy),
    .quotient (sp_mean)
  );

  csrm_div #(.COUNT_BITS(COUNT_BITS)) u_div_noise (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (new_noise),
    .divisor  (no_cnt),
    .busy     (no_busy),
    .quotient (no_mean)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.out_index        <= work.elem;
      out_data.speech_mean      <= sp_mean;
      out_data.noise_mean       <= no_mean;
      out_data.end_of_vector    <= work.eov;
      out_data.end_of_utterance <= work.last;
    end
  end

endmodule

// ===== design/class_split_running_mean_core.sv =====
// Top level of the class-split running mean block: configuration registers,
// front end, queue and back end. Depends on csrm_pkg and all csrm_* modules.
//
// Usage: feature frames enter one element per transaction on the input channel
// (in_valid/in_stall/in_data). The element with index 0 carries the frame's
// three class scores and its first/last marks; the frame is noise when score_a
// or score_c exceeds score_b, otherwise speech. Elements at or beyond the
// configured frame dimension are dropped without effect. On a frame that
// closes a period, or on the last frame of an utterance, each element yields
// one result transaction on the output channel (out_valid/out_stall/out_data)
// with the speech and noise means of that element, Q7.8, truncated.
// Throughput: the front takes one transaction per cycle while the two-entry
// queue has room. The back handles one element at a time: a memory read,
// then a read-modify-write, and on an element that emits, a wait for the
// bit-serial dividers that run for both classes side by side.
// Reset clears counts, the period phase and the handshake state and restores
// period_frames to 10 and frame_dim to 40; sum memories are not cleared, a
// first frame writes them. When the receiver stalls, the finished result holds
// in the output register, the back waits, and the front keeps filling the queue.
// Registers are written over the APB-style port at byte address 0
// (period_frames) and 4 (frame_dim). The user must write them only while the
// block is idle; the block itself does not enforce this.

module class_split_running_mean_core #(
  parameter int MAX_DIM    = csrm_pkg::MAX_DIM_DEFAULT,
  parameter int COUNT_BITS = csrm_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  csrm_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output csrm_pkg::out_item_t  out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import csrm_pkg::*;

  localparam int QW = $bits(work_item_t) + 2 * COUNT_BITS;

  logic [PERIOD_W-1:0]   period_frames;
  logic [DIM_W-1:0]      frame_dim;
  logic                  cfg_write;
  logic                  reg_sel;

  logic                  q_full;
  logic                  q_push;
  logic                  q_pop;
  logic                  q_valid;
  logic [QW-1:0]         q_push_data;
  logic [QW-1:0]         q_pop_data;
  work_item_t            push_entry;
  work_item_t            pop_entry;
  logic [COUNT_BITS-1:0] push_sp_cnt;
  logic [COUNT_BITS-1:0] push_no_cnt;
  logic [COUNT_BITS-1:0] pop_sp_cnt;
  logic [COUNT_BITS-1:0] pop_no_cnt;

  // Configuration port: always ready, written in the access cycle.
  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    unique case (reg_sel)
      REG_PERIOD: prdata = {{(32 - PERIOD_W){1'b0}}, period_frames};
      REG_DIM:    prdata = {{(32 - DIM_W){1'b0}}, frame_dim};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period_frames <= PERIOD_RESET;
      frame_dim     <= DIM_RESET;
    end else if (cfg_write) begin
      if (reg_sel == REG_PERIOD) begin
        period_frames <= pwdata[PERIOD_W-1:0];
      end else begin
        frame_dim <= pwdata[DIM_W-1:0];
      end
    end
  end

  csrm_front #(
    .MAX_DIM    (MAX_DIM),
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .period_frames (period_frames),
    .frame_dim     (frame_dim),
    .q_full        (q_full),
    .push          (q_push),
    .entry         (push_entry),
    .speech_count  (push_sp_cnt),
    .noise_count   (push_no_cnt)
  );

  assign q_push_data = {push_entry, push_sp_cnt, push_no_cnt};
  assign {pop_entry, pop_sp_cnt, pop_no_cnt} = q_pop_data;

  csrm_queue #(.W(QW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_pop_data)
  );

  csrm_back #(
    .MAX_DIM    (MAX_DIM),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_entry        (pop_entry),
    .q_speech_count (pop_sp_cnt),
    .q_noise_count  (pop_no_cnt),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data)
  );

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for class_split_running_mean_core.
// Depends on csrm_pkg and the RTL under design/; it reads no files.
`timescale 1ns / 100ps

module tb;
  import csrm_pkg::*;

  localparam int unsigned CNT_MAX     = (1 << COUNT_BITS_DEFAULT) - 1;
  localparam int unsigned HOLD_CYCLES = 400;
  // An emitting element waits for both dividers in the back end, and up to two
  // more wait in the queue plus one in the output register.
  localparam int unsigned TAIL_CYCLES = 150;
  localparam int unsigned LIMIT       = 2_000_000;

  // Scoreboard: a cycle-free copy of the block's arithmetic. It keeps its own
  // sums, frame counts, period position and per-frame header latches, and it
  // queues the means that the accepted element transactions should produce.
  class mean_scoreboard;
    int unsigned period_cfg;
    int unsigned dim_cfg;
    longint      speech_acc [64];
    longint      noise_acc [64];
    bit          written [64];
    int unsigned speech_cnt;
    int unsigned noise_cnt;
    int unsigned period_pos;
    bit          hdr_noise;
    bit          hdr_drop;
    bit          hdr_first;
    bit          hdr_last;
    bit          hdr_emit;
    out_item_t   expected_means[$];
    int unsigned errors;

    function new();
      period_cfg = PERIOD_RESET;
      dim_cfg    = DIM_RESET;
      foreach (written[i]) begin
        written[i]    = 1'b0;
        speech_acc[i] = 0;
        noise_acc[i]  = 0;
      end
      speech_cnt = 0;
      noise_cnt  = 0;
      period_pos = 0;
      hdr_noise  = 1'b0;
      hdr_drop   = 1'b0;
      hdr_first  = 1'b0;
      hdr_last   = 1'b0;
      hdr_emit   = 1'b0;
      errors     = 0;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
    endfunction

    function void set_reg(logic idx, logic [31:0] val);
      if (idx == REG_PERIOD) period_cfg = val[PERIOD_W-1:0];
      else dim_cfg = val[DIM_W-1:0];
    endfunction

    // A dimension of zero behaves as one, anything above 64 as 64.
    function int unsigned active_dim();
      int unsigned d;
      d = dim_cfg;
      if (d == 0) d = 1;
      if (d > MAX_DIM_DEFAULT) d = MAX_DIM_DEFAULT;
      return d;
    endfunction

    function longint class_mean(longint sum, int unsigned cnt);
      if (cnt == 0) return 0;
      return sum / longint'(cnt);
    endfunction

    function void absorb_element(in_item_t it);
      int unsigned d;
      int unsigned e;
      int unsigned per;
      longint      x;
      out_item_t   m;
      d = active_dim();
      e = it.element_index;
      x = $signed(it.feature_value);
      if (e >= d) return;
      // Element 0 carries the frame header: class, marks, counts and period.
      if (e == 0) begin
        hdr_noise = ($signed(it.score_a) > $signed(it.score_b)) ||
                    ($signed(it.score_c) > $signed(it.score_b));
        hdr_first = it.first_frame;
        hdr_last  = it.last_frame;
        per = (period_cfg == 0) ? 1 : period_cfg;
        if (hdr_first) begin
          speech_cnt = 0;
          noise_cnt  = 0;
          period_pos = 0;
        end
        if (hdr_noise) begin
          hdr_drop = noise_cnt >= CNT_MAX;
          if (!hdr_drop) noise_cnt++;
        end else begin
          hdr_drop = speech_cnt >= CNT_MAX;
          if (!hdr_drop) speech_cnt++;
        end
        hdr_emit   = hdr_last || (period_pos + 1 >= per);
        period_pos = hdr_emit ? 0 : ((period_pos + 1) & 32'hFFFF);
      end
      if (hdr_first) begin
        speech_acc[e] = hdr_noise ? 0 : x;
        noise_acc[e]  = hdr_noise ? x : 0;
        written[e]    = 1'b1;
      end else if (!hdr_drop) begin
        if (hdr_noise) noise_acc[e] += x;
        else speech_acc[e] += x;
      end
      if (!hdr_emit) return;
      m.out_index        = e[ELEM_W-1:0];
      m.speech_mean      = 16'(class_mean(speech_acc[e], speech_cnt));
      m.noise_mean       = 16'(class_mean(noise_acc[e], noise_cnt));
      m.end_of_vector    = (e == d - 1);
      m.end_of_utterance = hdr_last;
      expected_means = {expected_means, m};
    endfunction

    function void check_means(out_item_t got);
      out_item_t want;
      bit        bad;
      if (expected_means.size() == 0) begin
        flag($sformatf("unexpected result idx %0d speech %0d noise %0d eov %0b eou %0b",
                       got.out_index, got.speech_mean, got.noise_mean,
                       got.end_of_vector, got.end_of_utterance));
        return;
      end
      want = expected_means.pop_front();
      bad = (got.out_index !== want.out_index) ||
            (got.speech_mean !== want.speech_mean) ||
            (got.noise_mean !== want.noise_mean) ||
            (got.end_of_vector !== want.end_of_vector) ||
            (got.end_of_utterance !== want.end_of_utterance);
      if (bad)
        flag($sformatf({"expected idx %0d speech %0d noise %0d eov %0b eou %0b, ",
                        "got idx %0d speech %0d noise %0d eov %0b eou %0b"},
                       want.out_index, want.speech_mean, want.noise_mean,
                       want.end_of_vector, want.end_of_utterance,
                       got.out_index, got.speech_mean, got.noise_mean,
                       got.end_of_vector, got.end_of_utterance));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  mean_scoreboard sb;
  int unsigned    items_sent = 0;
  int unsigned    pressure_at = 0;
  int unsigned    cycle_count = 0;
  int unsigned    hold_left = 0;
  bit             hold_trigger = 1'b0;
  bit             hold_taken = 1'b0;
  // While calm is set neither side idles or stalls at random.
  bit             calm = 1'b0;

  class_split_running_mean_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // The watchdog ends a run that hangs, for example when results go missing.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("** class_split_running_mean_core: FAILED **");
      $finish;
    end
  end

  // Result side. Every output transaction is checked at the edge that accepts
  // it. The stall is random while calm is clear, and one long hold-off lets
  // the queue fill so that the block has to stall its own input.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_means(out_data);
      if (hold_trigger && !hold_taken) begin
        hold_taken <= 1'b1;
        hold_left  <= HOLD_CYCLES;
        out_stall  <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 37);
      end
    end
  end

  // One APB transfer, setup then access; the bus returns to idle after it
  // so that back-to-back transfers never reassign psel in the same step.
  task automatic apb_transfer(input logic wr, input logic idx, input logic [31:0] wdata,
                              output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic verify_reg(input logic idx, input logic [31:0] want);
    logic [31:0] rd;
    logic [31:0] mask;
    mask = (idx == REG_PERIOD) ? 32'h0000_FFFF : 32'h0000_007F;
    apb_transfer(1'b0, idx, '0, rd);
    if ((rd & mask) !== (want & mask))
      sb.flag($sformatf("register %0d reads %0h, expected %0h", idx, rd & mask, want & mask));
  endtask

  task automatic cfg_write(input logic idx, input logic [31:0] val);
    logic [31:0] unused;
    apb_transfer(1'b1, idx, val, unused);
    sb.set_reg(idx, val);
    verify_reg(idx, val);
  endtask

  // Lets every expected result arrive, then gives the back end time to
  // finish elements that emit nothing.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.expected_means.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  function automatic int rand16();
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k == 0) return 32767;
    if (k == 1) return -32768;
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic in_item_t elem(int unsigned e, int v, int a, int b, int c,
                                    bit first, bit last);
    in_item_t it;
    it.feature_value = 16'(v);
    it.element_index = 6'(e);
    it.score_a       = 16'(a);
    it.score_b       = 16'(b);
    it.score_c       = 16'(c);
    it.first_frame   = first;
    it.last_frame    = last;
    return it;
  endfunction

  function automatic in_item_t random_item(int unsigned e);
    return elem(e, rand16(), rand16(), rand16(), rand16(),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endfunction

  // Scores for a frame of the wanted class. Noise needs score_a or score_c
  // above score_b; speech keeps both at or below it, ties included.
  function automatic void pick_scores(input bit noisy, output int a, output int b,
                                      output int c);
    int unsigned which;
    if (noisy) begin
      b = int'($urandom_range(0, 65534)) - 32768;
      a = rand16();
      c = rand16();
      which = $urandom_range(0, 2);
      if (which != 1) a = b + 1 + int'($urandom_range(0, 32766 - b));
      if (which != 0) c = b + 1 + int'($urandom_range(0, 32766 - b));
    end else begin
      b = rand16();
      a = b - int'($urandom_range(0, b + 32768));
      c = b - int'($urandom_range(0, b + 32768));
    end
  endfunction

  // Offers one element transaction and holds it until accepted. An element
  // that would read a sum entry no first frame has written is turned into the
  // header of a new utterance instead.
  task automatic push_item(input in_item_t it);
    int unsigned e;
    int unsigned d;
    e = it.element_index;
    d = sb.active_dim();
    if (e < d && !sb.written[e] && !((e == 0) ? it.first_frame : sb.hdr_first)) begin
      it.element_index = '0;
      it.first_frame   = 1'b1;
    end
    while (!calm && $urandom_range(0, 99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.absorb_element(it);
    items_sent++;
    if (items_sent == pressure_at) hold_trigger <= 1'b1;
  endtask

  // Elements 0 .. count-1 of one frame; only the header carries real scores
  // and marks, the rest carry random ones that must be ignored.
  task automatic send_frame(input bit first, input bit last, input bit noisy,
                            input int unsigned count);
    int          a;
    int          b;
    int          c;
    int unsigned e;
    pick_scores(noisy, a, b, c);
    for (e = 0; e < count; e++) begin
      if (e == 0) push_item(elem(0, rand16(), a, b, c, first, last));
      else push_item(random_item(e));
    end
  endtask

  // Mostly whole utterances with random content; some stray elements and
  // some truncated frames or utterances without a closing frame.
  task automatic random_phase(input int unsigned budget);
    int unsigned start;
    int unsigned nfr;
    int unsigned d;
    int unsigned cut;
    int unsigned f;
    start = items_sent;
    while (items_sent - start < budget) begin
      d = sb.active_dim();
      if ($urandom_range(0, 99) < 12) begin
        push_item(random_item($urandom_range(0, 63)));
      end else begin
        nfr = $urandom_range(1, (d > 24) ? 3 : 8);
        for (f = 0; f < nfr; f++) begin
          cut = ($urandom_range(0, 99) < 8) ? $urandom_range(1, d) : d;
          send_frame((f == 0) && ($urandom_range(0, 4) != 0),
                     (f == nfr - 1) && ($urandom_range(0, 9) != 0),
                     1'($urandom_range(0, 1)), cut);
        end
      end
    end
  endtask

  task automatic run_phase(input int unsigned period, input int unsigned dim,
                           input int unsigned budget);
    settle();
    cfg_write(REG_PERIOD, period);
    cfg_write(REG_DIM, dim);
    random_phase(budget);
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    verify_reg(REG_PERIOD, PERIOD_RESET);
    verify_reg(REG_DIM, DIM_RESET);

    // Directed frames at three elements and a period of two frames.
    cfg_write(REG_PERIOD, 2);
    cfg_write(REG_DIM, 3);
    // Speech frame opening an utterance, full-scale values.
    push_item(elem(0, 32767, -32768, 32767, -32768, 1'b1, 1'b0));
    push_item(elem(1, -32768, 32767, -32768, 32767, 1'b0, 1'b1));
    push_item(elem(2, 1, 0, 0, 0, 1'b1, 1'b1));
    // Elements at and beyond the dimension are ignored.
    push_item(elem(3, 32767, 32767, -32768, 32767, 1'b1, 1'b1));
    push_item(elem(63, -32768, 32767, -32768, 32767, 1'b0, 1'b1));
    // Noise because score_a is above score_b; this frame closes the period.
    push_item(elem(0, -32768, 32767, -32768, -32768, 1'b0, 1'b0));
    push_item(elem(1, 32767, 0, 0, 0, 1'b0, 1'b0));
    push_item(elem(2, -1, 0, 0, 0, 1'b0, 1'b0));
    // Noise because score_c alone is above score_b.
    push_item(elem(0, 256, 0, 0, 1, 1'b0, 1'b0));
    push_item(elem(1, -256, -32768, 32767, -32768, 1'b1, 1'b1));
    push_item(elem(2, 7, 0, 0, 0, 1'b0, 1'b0));
    // All three scores tie, which is speech; the last frame forces output.
    push_item(elem(0, -5, 5, 5, 5, 1'b0, 1'b1));
    push_item(elem(1, 3, 0, 0, 0, 1'b0, 1'b0));
    push_item(elem(2, 32767, 0, 0, 0, 1'b0, 1'b0));
    // A one-frame utterance with noise only, so the speech mean is zero.
    push_item(elem(0, 100, 1, 0, 0, 1'b1, 1'b1));
    push_item(elem(1, -100, 0, 0, 0, 1'b0, 1'b0));
    push_item(elem(2, 55, 0, 0, 0, 1'b0, 1'b0));

    // Period zero acts as one and dimension zero as one: every element
    // emits. A negative sum of -3 over two frames must truncate to -1.
    settle();
    cfg_write(REG_PERIOD, 0);
    cfg_write(REG_DIM, 0);
    push_item(elem(0, -3, -9, 0, -9, 1'b1, 1'b0));
    push_item(elem(0, 5, 9, 0, 0, 1'b0, 1'b0));
    push_item(elem(0, 0, 0, 0, 0, 1'b0, 1'b1));

    // Random phases over several settings, the reset values among them.
    run_phase(PERIOD_RESET, DIM_RESET, 170);
    // Full dimension with no random idling; partway in, the receiver holds
    // off long enough that the queue fills and the input stalls.
    calm = 1'b1;
    pressure_at = items_sent + 40;
    run_phase(1, 64, 190);
    calm = 1'b0;
    run_phase(3, 127, 150);
    run_phase(2, 7, 150);
    run_phase(0, 2, 130);
    run_phase(5, 1, 130);
    run_phase($urandom_range(1, 12), $urandom_range(1, 64), 150);
    run_phase($urandom_range(1, 12), $urandom_range(1, 64), 150);

    // A result that never arrives keeps settle waiting until the watchdog.
    settle();
    if (sb.errors == 0) begin
      $display("** class_split_running_mean_core: PASSED **");
    end else begin
      $display("** class_split_running_mean_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== class_split_running_mean_core.f =====
design/csrm_pkg.sv
design/csrm_div.sv
design/csrm_queue.sv
design/csrm_front.sv
design/csrm_back.sv
design/class_split_running_mean_core.sv
sim/tb.sv
